### rtl/core/ctsb_pkg.sv
// package: item types, microcode fields and control program of the cartesian tree builder
`default_nettype none

package ctsb_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int LINK_W        = 11;
    localparam int PC_W          = 4;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] sort_key;
        logic signed [31:0] priority_req;
        logic               final_insert;
        logic [9:0]         node_position;
    } cmd_item_t;

    typedef struct packed {
        logic [LINK_W-1:0] parent_ref;
        logic [LINK_W-1:0] left_ref;
        logic [LINK_W-1:0] right_ref;
    } link_item_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CLEAR,
        ACT_LATCH,
        ACT_POP,
        ACT_LOAD_TOP,
        ACT_LINK_LEFT,
        ACT_PUSH,
        ACT_FLUSH_STEP,
        ACT_FLUSH_LINK,
        ACT_OUT_LOAD
    } act_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_CLR_MORE,
        COND_IN_READ,
        COND_FULL,
        COND_NO_POP,
        COND_FL_DONE,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] tgt;
        logic            wait_in;
        logic            hold_false;
    } ucode_t;

    typedef struct packed {
        logic in_accept;
        logic clr_more;
        logic in_read;
        logic full;
        logic pop_ok;
        logic fl_done;
        logic out_free;
    } flags_t;

    localparam logic [PC_W-1:0] STEP_CLR    = 4'd0;
    localparam logic [PC_W-1:0] STEP_IDLE   = 4'd1;
    localparam logic [PC_W-1:0] STEP_FULLCK = 4'd2;
    localparam logic [PC_W-1:0] STEP_CHK    = 4'd3;
    localparam logic [PC_W-1:0] STEP_POPW   = 4'd4;
    localparam logic [PC_W-1:0] STEP_LEFT   = 4'd5;
    localparam logic [PC_W-1:0] STEP_PUSH   = 4'd6;
    localparam logic [PC_W-1:0] STEP_FCHK   = 4'd7;
    localparam logic [PC_W-1:0] STEP_FLW    = 4'd8;
    localparam logic [PC_W-1:0] STEP_RDW    = 4'd9;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{act: ACT_NONE, cond: COND_ALWAYS, tgt: STEP_IDLE, wait_in: 1'b0,
              hold_false: 1'b0};
        unique case (pc)
            STEP_CLR:    w = '{act: ACT_CLEAR, cond: COND_CLR_MORE, tgt: STEP_CLR,
                               wait_in: 1'b0, hold_false: 1'b0};
            STEP_IDLE:   w = '{act: ACT_LATCH, cond: COND_IN_READ, tgt: STEP_RDW,
                               wait_in: 1'b1, hold_false: 1'b0};
            STEP_FULLCK: w = '{act: ACT_NONE, cond: COND_FULL, tgt: STEP_FCHK,
                               wait_in: 1'b0, hold_false: 1'b0};
            STEP_CHK:    w = '{act: ACT_POP, cond: COND_NO_POP, tgt: STEP_LEFT,
                               wait_in: 1'b0, hold_false: 1'b0};
            STEP_POPW:   w = '{act: ACT_LOAD_TOP, cond: COND_ALWAYS, tgt: STEP_CHK,
                               wait_in: 1'b0, hold_false: 1'b0};
            STEP_LEFT:   w = '{act: ACT_LINK_LEFT, cond: COND_NEVER, tgt: STEP_IDLE,
                               wait_in: 1'b0, hold_false: 1'b0};
            STEP_PUSH:   w = '{act: ACT_PUSH, cond: COND_NEVER, tgt: STEP_IDLE,
                               wait_in: 1'b0, hold_false: 1'b0};
            STEP_FCHK:   w = '{act: ACT_FLUSH_STEP, cond: COND_FL_DONE, tgt: STEP_IDLE,
                               wait_in: 1'b0, hold_false: 1'b0};
            STEP_FLW:    w = '{act: ACT_FLUSH_LINK, cond: COND_ALWAYS, tgt: STEP_FCHK,
                               wait_in: 1'b0, hold_false: 1'b0};
            STEP_RDW:    w = '{act: ACT_OUT_LOAD, cond: COND_OUT_FREE, tgt: STEP_IDLE,
                               wait_in: 1'b0, hold_false: 1'b1};
            default:     w = '{act: ACT_NONE, cond: COND_ALWAYS, tgt: STEP_IDLE,
                               wait_in: 1'b0, hold_false: 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ctsb_sequencer.sv
// microcode sequencer: step counter, control program lookup and conditional jumps
`default_nettype none

module ctsb_sequencer
    import ctsb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ucode_t ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            cond_hit;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:    cond_hit = 1'b0;
            COND_ALWAYS:   cond_hit = 1'b1;
            COND_CLR_MORE: cond_hit = flags.clr_more;
            COND_IN_READ:  cond_hit = flags.in_read;
            COND_FULL:     cond_hit = flags.full;
            COND_NO_POP:   cond_hit = !flags.pop_ok;
            COND_FL_DONE:  cond_hit = flags.fl_done;
            COND_OUT_FREE: cond_hit = flags.out_free;
            default:       cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (ctrl.wait_in && !flags.in_accept)
        begin
            pc_next = pc_reg;
        end
        else if (cond_hit)
        begin
            pc_next = ctrl.tgt;
        end
        else if (ctrl.hold_false)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_CLR;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ctsb_link_store.sv
// parent, left and right link tables, one write port each and a shared registered read
`default_nettype none

module ctsb_link_store
    import ctsb_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int AW        = $clog2(DEF_MAX_NODES)
)
(
    input  logic              clk,
    input  logic              par_we,
    input  logic [AW-1:0]     par_addr,
    input  logic [LINK_W-1:0] par_data,
    input  logic              lft_we,
    input  logic [AW-1:0]     lft_addr,
    input  logic [LINK_W-1:0] lft_data,
    input  logic              rgt_we,
    input  logic [AW-1:0]     rgt_addr,
    input  logic [LINK_W-1:0] rgt_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output link_item_t        rd_data
);

    logic [LINK_W-1:0] par_mem [MAX_NODES];
    logic [LINK_W-1:0] lft_mem [MAX_NODES];
    logic [LINK_W-1:0] rgt_mem [MAX_NODES];
    link_item_t        rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_addr] <= par_data;
        end
        if (lft_we)
        begin
            lft_mem[lft_addr] <= lft_data;
        end
        if (rgt_we)
        begin
            rgt_mem[rgt_addr] <= rgt_data;
        end
        if (rd_en)
        begin
            rd_data_reg.parent_ref <= par_mem[rd_addr];
            rd_data_reg.left_ref   <= lft_mem[rd_addr];
            rd_data_reg.right_ref  <= rgt_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/ctsb_datapath.sv
// datapath: stack memory, top-of-stack and counters, link writes and result register
`default_nettype none

module ctsb_datapath
    import ctsb_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  ucode_t     ctrl,
    input  logic       cmd_accept,
    input  cmd_item_t  cmd_item,
    output flags_t     flags,
    output logic       link_valid,
    input  logic       link_stall,
    output link_item_t link_item
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int SW = AW + 32;

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      depth_reg;
    logic               child_valid_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               out_valid_reg;
    logic [AW-1:0]      top_pos_reg;
    logic signed [31:0] top_prio_reg;
    logic [AW-1:0]      child_reg;
    logic signed [31:0] prio_reg;
    logic               final_reg;
    logic               in_range_reg;
    link_item_t         out_data_reg;
    logic [SW-1:0]      stk_rdata_reg;

    logic [SW-1:0]      stack_mem [MAX_NODES];

    logic               stk_we;
    logic [AW-1:0]      stk_waddr;
    logic [SW-1:0]      stk_wdata;
    logic               stk_re;
    logic [AW-1:0]      stk_raddr;

    logic               par_we;
    logic [AW-1:0]      par_addr;
    logic [LINK_W-1:0]  par_data;
    logic               lft_we;
    logic [AW-1:0]      lft_addr;
    logic [LINK_W-1:0]  lft_data;
    logic               rgt_we;
    logic [AW-1:0]      rgt_addr;
    logic [LINK_W-1:0]  rgt_data;
    logic               lnk_re;
    logic [AW-1:0]      lnk_raddr;
    link_item_t         lnk_rdata;

    logic [AW-1:0]      me_pos;
    logic [AW-1:0]      up_pos;
    logic               pop_ok;
    logic               out_free;
    logic               out_load;

    function automatic logic [LINK_W-1:0] link_of(input logic [AW-1:0] p);
        logic [AW:0] s;
        s = {1'b0, p} + (AW + 1)'(1);
        return LINK_W'(s);
    endfunction

    assign me_pos   = AW'(count_reg);
    assign up_pos   = stk_rdata_reg[SW-1:32];
    assign pop_ok   = (depth_reg != '0) && (top_prio_reg > prio_reg);
    assign out_free = !out_valid_reg || !link_stall;
    assign out_load = (ctrl.act == ACT_OUT_LOAD) && out_free;

    assign flags.in_accept = cmd_accept;
    assign flags.clr_more  = (clr_addr_reg != AW'(MAX_NODES - 1));
    assign flags.in_read   = (cmd_item.operation == OP_READ);
    assign flags.full      = (count_reg >= CW'(MAX_NODES));
    assign flags.pop_ok    = pop_ok;
    assign flags.fl_done   = !final_reg || (depth_reg <= CW'(1));
    assign flags.out_free  = out_free;

    assign link_valid = out_valid_reg;
    assign link_item  = out_data_reg;

    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = {top_pos_reg, top_prio_reg};
        stk_re    = 1'b0;
        stk_raddr = AW'(depth_reg - CW'(2));
        par_we    = 1'b0;
        par_addr  = child_reg;
        par_data  = link_of(top_pos_reg);
        lft_we    = 1'b0;
        lft_addr  = me_pos;
        lft_data  = link_of(child_reg);
        rgt_we    = 1'b0;
        rgt_addr  = top_pos_reg;
        rgt_data  = link_of(child_reg);
        lnk_re    = 1'b0;
        lnk_raddr = AW'(cmd_item.node_position);
        unique case (ctrl.act)
            ACT_CLEAR:
            begin
                par_we   = 1'b1;
                par_addr = clr_addr_reg;
                par_data = '0;
                lft_we   = 1'b1;
                lft_addr = clr_addr_reg;
                lft_data = '0;
                rgt_we   = 1'b1;
                rgt_addr = clr_addr_reg;
                rgt_data = '0;
            end
            ACT_LATCH:
            begin
                lnk_re = cmd_accept && (cmd_item.operation == OP_READ);
            end
            ACT_POP:
            begin
                rgt_we = pop_ok && child_valid_reg;
                par_we = pop_ok && child_valid_reg;
                stk_re = pop_ok && (depth_reg >= CW'(2));
            end
            ACT_LINK_LEFT:
            begin
                lft_we   = child_valid_reg;
                par_we   = child_valid_reg;
                par_data = link_of(me_pos);
            end
            ACT_PUSH:
            begin
                stk_we    = (depth_reg != '0);
                stk_waddr = AW'(depth_reg - CW'(1));
            end
            ACT_FLUSH_STEP:
            begin
                stk_re = final_reg && (depth_reg > CW'(1));
            end
            ACT_FLUSH_LINK:
            begin
                rgt_we   = 1'b1;
                rgt_addr = up_pos;
                rgt_data = link_of(top_pos_reg);
                par_we   = 1'b1;
                par_addr = top_pos_reg;
                par_data = link_of(up_pos);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rdata_reg <= stack_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            depth_reg       <= '0;
            child_valid_reg <= 1'b0;
            clr_addr_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            case (ctrl.act)
                ACT_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                end
                ACT_LATCH:
                begin
                    if (cmd_accept)
                    begin
                        child_valid_reg <= 1'b0;
                    end
                end
                ACT_POP:
                begin
                    if (pop_ok)
                    begin
                        child_valid_reg <= 1'b1;
                        depth_reg       <= depth_reg - CW'(1);
                    end
                end
                ACT_PUSH:
                begin
                    depth_reg       <= depth_reg + CW'(1);
                    count_reg       <= count_reg + CW'(1);
                    child_valid_reg <= 1'b0;
                end
                ACT_FLUSH_STEP:
                begin
                    if (final_reg)
                    begin
                        if (depth_reg > CW'(1))
                        begin
                            depth_reg <= depth_reg - CW'(1);
                        end
                        else
                        begin
                            depth_reg <= '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!link_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.act)
            ACT_LATCH:
            begin
                if (cmd_accept)
                begin
                    prio_reg     <= cmd_item.priority_req;
                    final_reg    <= cmd_item.final_insert;
                    in_range_reg <= (32'(cmd_item.node_position) < 32'(MAX_NODES));
                end
            end
            ACT_POP:
            begin
                if (pop_ok)
                begin
                    child_reg <= top_pos_reg;
                end
            end
            ACT_LOAD_TOP:
            begin
                if (depth_reg != '0)
                begin
                    top_pos_reg  <= stk_rdata_reg[SW-1:32];
                    top_prio_reg <= stk_rdata_reg[31:0];
                end
            end
            ACT_PUSH:
            begin
                top_pos_reg  <= me_pos;
                top_prio_reg <= prio_reg;
            end
            ACT_FLUSH_LINK:
            begin
                top_pos_reg  <= stk_rdata_reg[SW-1:32];
                top_prio_reg <= stk_rdata_reg[31:0];
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_data_reg <= in_range_reg ? lnk_rdata : '0;
        end
    end

    ctsb_link_store #(
        .MAX_NODES (MAX_NODES),
        .AW        (AW)
    ) u_links (
        .clk      (clk),
        .par_we   (par_we),
        .par_addr (par_addr),
        .par_data (par_data),
        .lft_we   (lft_we),
        .lft_addr (lft_addr),
        .lft_data (lft_data),
        .rgt_we   (rgt_we),
        .rgt_addr (rgt_addr),
        .rgt_data (rgt_data),
        .rd_en    (lnk_re),
        .rd_addr  (lnk_raddr),
        .rd_data  (lnk_rdata)
    );

endmodule

`default_nettype wire

### rtl/core/cartesian_tree_stack_builder.sv
// top level of the cartesian tree builder: sequencer and datapath
//
//  channel | role   | handshake               | payload
//  cmd     | input  | cmd_valid / cmd_stall   | cmd_item  (insert or read)
//  link    | output | link_valid / link_stall | link_item (parent, left, right)
//
//  insert: full check, pop loop (stack memory read per popped node), left link step, push, flush check
//  insert at capacity: full check then flush check, node dropped
//  final insert: a stack read and a link step per stacked node above the bottom one (right-edge flush)
//  read: result taken from the registered link table read
//  after reset a clearing pass zeroes the link tables, cmd stalled
//  a read waits while the result register holds an untaken transfer
`default_nettype none

module cartesian_tree_stack_builder
    import ctsb_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  cmd_item_t  cmd_item,
    output logic       link_valid,
    input  logic       link_stall,
    output link_item_t link_item
);

    ucode_t ctrl;
    flags_t flags;
    logic   cmd_accept;

    assign cmd_stall  = !ctrl.wait_in;
    assign cmd_accept = cmd_valid && !cmd_stall;

    ctsb_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    ctsb_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cmd_accept (cmd_accept),
        .cmd_item   (cmd_item),
        .flags      (flags),
        .link_valid (link_valid),
        .link_stall (link_stall),
        .link_item  (link_item)
    );

endmodule

`default_nettype wire

### rtl/core/ctsb_checker.sv
// port-level checker for the cartesian tree builder and its bind
`default_nettype none

module ctsb_checker
    import ctsb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_stall,
    input cmd_item_t  cmd_item,
    input logic       link_valid,
    input logic       link_stall,
    input link_item_t link_item
);

    // one item at a time
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("cmd accepted on two consecutive cycles");

    // results appear only from the read wait step
    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(link_valid) |-> $past(cmd_stall))
        else $error("result raised while cmd was open");

    // clearing pass holds off commands after reset
    a_clear_after_reset: assert property (@(posedge clk)
        !rst_n |=> cmd_stall)
        else $error("cmd open right after reset");

    a_link_hold: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid && link_stall |=> link_valid && $stable(link_item))
        else $error("stalled result changed");

endmodule

bind cartesian_tree_stack_builder ctsb_checker u_ctsb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_item   (cmd_item),
    .link_valid (link_valid),
    .link_stall (link_stall),
    .link_item  (link_item)
);

`default_nettype wire
